/* design/b64u_pkg.sv */
`default_nettype none
// ============================================================================
// b64u_pkg
// shared types, constants and the sextet-to-character map of the base64url
// encoder
// ============================================================================
package b64u_pkg;

    // width of one 6-bit group and of one ascii character
    localparam int unsigned GRP_W  = 6;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned BYTE_W = 8;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // alphabet boundaries
    localparam logic [GRP_W-1:0]  UPPER_END = 6'd26;
    localparam logic [GRP_W-1:0]  LOWER_END = 6'd52;
    localparam logic [GRP_W-1:0]  DIGIT_END = 6'd62;
    localparam logic [GRP_W-1:0]  GRP_DASH  = 6'd62;
    localparam logic [CHAR_W-1:0] ASC_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASC_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASC_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASC_DASH    = 7'h2D;
    localparam logic [CHAR_W-1:0] ASC_USCORE  = 7'h5F;

    // one classified byte: first group, optional second group, final mark
    typedef struct packed {
        logic [GRP_W-1:0] grp0;
        logic [GRP_W-1:0] grp1;
        logic             two;
        logic             fin;
    } b64u_entry_t;

    // front status seen by the top level
    typedef struct packed {
        logic at_block_start;
    } b64u_front_stat_t;

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } b64u_queue_stat_t;

    // 6-bit group to url-safe ascii character
    function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [GRP_W-1:0] grp);
        logic [CHAR_W-1:0] g7;
        logic [CHAR_W-1:0] res;
        g7 = {1'b0, grp};
        if (grp < UPPER_END)
            res = ASC_UPPER_A + g7;
        else if (grp < LOWER_END)
            res = ASC_LOWER_A + g7 - {1'b0, UPPER_END};
        else if (grp < DIGIT_END)
            res = ASC_ZERO + g7 - {1'b0, LOWER_END};
        else if (grp == GRP_DASH)
            res = ASC_DASH;
        else
            res = ASC_USCORE;
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/b64u_in_if.sv */
`default_nettype none
// ============================================================================
// b64u_in_if
// byte channel into the encoder: valid, ready, message byte and final mark
// ============================================================================
interface b64u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       final_byte;

    modport source (output valid, output message_byte, output final_byte, input ready);
    modport sink   (input valid, input message_byte, input final_byte, output ready);
endinterface
`default_nettype wire

/* design/b64u_out_if.sv */
`default_nettype none
// ============================================================================
// b64u_out_if
// character channel out of the encoder: valid, ready, character and last mark
// ============================================================================
interface b64u_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] symbol_char;
    logic       last_symbol;

    modport source (output valid, output symbol_char, output last_symbol, input ready);
    modport sink   (input valid, input symbol_char, input last_symbol, output ready);
endinterface
`default_nettype wire

/* design/b64u_front.sv */
`default_nettype none
// ============================================================================
// b64u_front
// takes message bytes, tracks the 3-byte block phase and carried bits, and
// splits each byte into one or two 6-bit groups for the queue
// ============================================================================
module b64u_front
    import b64u_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic             in_final,
    input  wire logic             queue_full,
    output logic                  in_ready,
    output logic                  push,
    output b64u_entry_t           push_entry,
    output b64u_front_stat_t      stat
);

    typedef enum logic [2:0] {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;

    // accept whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;
    assign stat.at_block_start = (phase_reg == PH0);

    // split the byte by phase
    always_comb
    begin
        push_entry.fin = in_final;
        unique case (phase_reg)
            PH1:
            begin
                push_entry.grp0 = {carry_reg[1:0], in_byte[7:4]};
                push_entry.grp1 = {in_byte[3:0], 2'b00};
                push_entry.two  = in_final;
                phase_next      = PH2;
                carry_next      = in_byte[3:0];
            end
            PH2:
            begin
                push_entry.grp0 = {carry_reg, in_byte[7:6]};
                push_entry.grp1 = in_byte[5:0];
                push_entry.two  = 1'b1;
                phase_next      = PH0;
                carry_next      = 4'd0;
            end
            default:
            begin
                push_entry.grp0 = in_byte[7:2];
                push_entry.grp1 = {in_byte[1:0], 4'b0000};
                push_entry.two  = in_final;
                phase_next      = PH1;
                carry_next      = {2'b00, in_byte[1:0]};
            end
        endcase
        // a final byte ends the message
        if (in_final)
        begin
            phase_next = PH0;
            carry_next = 4'd0;
        end
    end

    // phase and carry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule
`default_nettype wire

/* design/b64u_queue.sv */
`default_nettype none
// ============================================================================
// b64u_queue
// short fifo of classified items between the front and the back
// ============================================================================
module b64u_queue
    import b64u_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  b64u_entry_t push_entry,
    input  wire logic  pop,
    output b64u_entry_t head,
    output logic       head_valid,
    output b64u_queue_stat_t stat
);

    b64u_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_valid = !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

/* design/b64u_back.sv */
`default_nettype none
// ============================================================================
// b64u_back
// drains the queue and sends one character per cycle while out_ready is
// high through an output register, holding the second group of an item
// until its turn
module b64u_back
    import b64u_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  b64u_entry_t      head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic             out_last
);

    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              sec_pend_reg;
    logic [GRP_W-1:0]  sec_grp_reg;
    logic              sec_last_reg;
    logic              load;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    // output register free or being emptied this cycle
    assign load = !valid_reg || out_ready;
    assign pop  = load && !sec_pend_reg && head_valid;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            sec_pend_reg <= 1'b0;
        end
        else if (load)
        begin
            if (sec_pend_reg)
            begin
                valid_reg    <= 1'b1;
                sec_pend_reg <= 1'b0;
            end
            else if (head_valid)
            begin
                valid_reg    <= 1'b1;
                sec_pend_reg <= head.two;
            end
            else
                valid_reg <= 1'b0;
        end
    end

    // character and held second group
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sec_pend_reg)
            begin
                char_reg <= sextet_to_ascii(sec_grp_reg);
                last_reg <= sec_last_reg;
            end
            else if (head_valid)
            begin
                char_reg     <= sextet_to_ascii(head.grp0);
                last_reg     <= 1'b0;
                sec_grp_reg  <= head.grp1;
                sec_last_reg <= head.fin;
            end
        end
    end

endmodule
`default_nettype wire

/* design/base64url_encoder.sv */
`default_nettype none
// ============================================================================
// base64url_encoder
// unpadded url-safe base64 encoder: one message byte in, one or two
// characters out, last character of the message marked
// ============================================================================
//  channel   direction  payload                        handshake
//  msg       in         message_byte[7:0], final_byte  valid / ready
//  sym       out        symbol_char[6:0], last_symbol  valid / ready
//
//  a byte emits one character, or two on the third byte of a block and on
//  the final byte; the back sends one character per cycle while sym ready
//  is high, so an item fills the output register with one or two
//  characters (about four characters per three bytes). the first
//  character of a byte is registered in a queue slot and then in the output
//  register before it is valid on sym. bytes enter through a two-entry
//  queue; msg ready drops while the queue holds two items, even in a cycle
//  where the back pops. reset clears the phase, queue and output valid;
//  after a final byte the next byte starts a new message.
// ============================================================================
module base64url_encoder
    import b64u_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64u_in_if.sink     msg,
    b64u_out_if.source  sym
);

    b64u_entry_t      push_entry;
    b64u_entry_t      head;
    b64u_front_stat_t front_stat;
    b64u_queue_stat_t queue_stat;
    logic             push;
    logic             pop;
    logic             head_valid;

    // byte classification
    b64u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (msg.valid),
        .in_byte    (msg.message_byte),
        .in_final   (msg.final_byte),
        .queue_full (queue_stat.full),
        .in_ready   (msg.ready),
        .push       (push),
        .push_entry (push_entry),
        .stat       (front_stat)
    );

    // item queue
    b64u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .stat       (queue_stat)
    );

    // character output
    b64u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (sym.valid),
        .out_ready  (sym.ready),
        .out_char   (sym.symbol_char),
        .out_last   (sym.last_symbol)
    );

    // a final byte returns the front to the start of a block
    a_final_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.ready && msg.final_byte |=> front_stat.at_block_start)
        else $error("phase not cleared after final byte");

    // no byte is taken while the queue is full
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        queue_stat.full |-> !msg.ready)
        else $error("byte accepted into a full queue");

    // queue never reports full and empty together
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_stat.full && queue_stat.empty))
        else $error("queue full and empty at once");

    // the back only pops an item that is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// self-checking bench for the unpadded base64url encoder: a table of known
// messages, then random messages of random length, with random stalls on
// both channels, a long output hold-off and a full drain pause; every
// character is compared with its typed row or an in-bench encoder of the stream
// ============================================================================
module tb_top;

    import b64u_pkg::*;

    localparam int RAND_ITEMS   = 1020;
    localparam int DIR_N        = 21;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [8*64-1:0] URL_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    // one expected character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } enc_sym_t;

    // one byte to send, with the characters typed in where known by hand
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              fin;
        logic              typed;
        logic              two;
        logic [7:0]        c0;
        logic [7:0]        c1;
        logic              l1;
    } byte_row_t;

    logic clk;
    logic rst_n;

    b64u_in_if  msg_if ();
    b64u_out_if sym_if ();

    base64url_encoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if.sink),
        .sym   (sym_if.source)
    );

    // encoder state kept by the bench
    logic [1:0]  enc_phase = 2'd0;
    logic [3:0]  enc_carry = 4'd0;

    enc_sym_t    pending_syms [$];
    byte_row_t   dir_rows [DIR_N];
    int          err_cnt   = 0;
    int          cycle_cnt = 0;
    bit          steady    = 1'b0;
    bit          hold_req  = 1'b0;
    bit          sink_hold = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // 6-bit group to url-safe character
    function automatic logic [CHAR_W-1:0] url_char(input logic [5:0] grp);
        logic [7:0] c;
        c = URL_CHARS[8 * (63 - int'(grp)) +: 8];
        return c[CHAR_W-1:0];
    endfunction

    // advance the encoder by one byte and return the characters it yields
    task automatic encode_byte(input logic [7:0] b, input logic fin,
                               output int n, output enc_sym_t s0, output enc_sym_t s1);
        s0 = '0;
        s1 = '0;
        case (enc_phase)
            2'd1:
            begin
                s0.ch = url_char({enc_carry[1:0], b[7:4]});
                s1.ch = url_char({b[3:0], 2'b00});
                s1.last = 1'b1;
                n = fin ? 2 : 1;
                enc_phase = 2'd2;
                enc_carry = b[3:0];
            end
            2'd2:
            begin
                s0.ch = url_char({enc_carry, b[7:6]});
                s1.ch = url_char(b[5:0]);
                s1.last = fin;
                n = 2;
                enc_phase = 2'd0;
                enc_carry = 4'd0;
            end
            default:
            begin
                s0.ch = url_char(b[7:2]);
                s1.ch = url_char({b[1:0], 4'b0000});
                s1.last = 1'b1;
                n = fin ? 2 : 1;
                enc_phase = 2'd1;
                enc_carry = {2'b00, b[1:0]};
            end
        endcase
        // a final byte closes the message
        if (fin)
        begin
            enc_phase = 2'd0;
            enc_carry = 4'd0;
        end
    endtask

    // offer one byte, wait for the handshake, queue its characters
    task automatic feed_byte(input byte_row_t row);
        int       n;
        enc_sym_t s0;
        enc_sym_t s1;
        if (!steady && $urandom_range(99) < 9)
        begin
            msg_if.valid        <= 1'b0;
            msg_if.message_byte <= 8'($urandom);
            msg_if.final_byte   <= 1'($urandom);
            @(posedge clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.message_byte <= row.data;
        msg_if.final_byte   <= row.fin;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        encode_byte(row.data, row.fin, n, s0, s1);
        // hand-typed rows override the computed characters
        if (row.typed)
        begin
            n = row.two ? 2 : 1;
            s0.ch = row.c0[CHAR_W-1:0];
            s0.last = 1'b0;
            s1.ch = row.c1[CHAR_W-1:0];
            s1.last = row.l1;
        end
        pending_syms.insert(pending_syms.size(), s0);
        if (n == 2)
            pending_syms.insert(pending_syms.size(), s1);
    endtask

    // stop offering bytes until every expected character has come out
    task automatic pause_sender();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_syms.size() != 0)
            @(posedge clk);
    endtask

    // output ready with random stalls, forced low during the hold-off
    initial
    begin : sym_ready_drive
        sym_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold)
                sym_if.ready <= 1'b0;
            else
                sym_if.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    // long hold-off of the receiver, counted here
    initial
    begin : sink_hold_off
        wait (hold_req);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    // compare each character item with the oldest expectation
    always @(posedge clk)
    begin : sym_check
        enc_sym_t want;
        if (rst_n && sym_if.valid && sym_if.ready)
        begin
            if (pending_syms.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got char %h last %b",
                         $time, sym_if.symbol_char, sym_if.last_symbol);
                err_cnt++;
            end
            else
            begin
                want = pending_syms.pop_front();
                if (sym_if.symbol_char !== want.ch)
                begin
                    $display("%0t: symbol_char mismatch: expected %h, got %h",
                             $time, want.ch, sym_if.symbol_char);
                    err_cnt++;
                end
                if (sym_if.last_symbol !== want.last)
                begin
                    $display("%0t: last_symbol mismatch: expected %b, got %b",
                             $time, want.last, sym_if.last_symbol);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // reset, directed table, random messages, drain
    initial
    begin : stimulus
        byte_row_t row;
        int        sent;
        int        msg_len;
        msg_if.valid        <= 1'b0;
        msg_if.message_byte <= 8'h00;
        msg_if.final_byte   <= 1'b0;
        rst_n               <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data, fin, typed, two, first char, second char, second marked last
        dir_rows = '{
            // one-byte messages: final at phase 0, extremes and the dash
            '{8'h00, 1'b1, 1'b1, 1'b1, "A", "A", 1'b1},
            '{8'hFF, 1'b1, 1'b1, 1'b1, "_", "w", 1'b1},
            '{8'hF8, 1'b1, 1'b1, 1'b1, "-", "A", 1'b1},
            // full block, final at phase 2
            '{8'h4D, 1'b0, 1'b1, 1'b0, "T", 8'h00, 1'b0},
            '{8'h61, 1'b0, 1'b1, 1'b0, "W", 8'h00, 1'b0},
            '{8'h6E, 1'b1, 1'b1, 1'b1, "F", "u", 1'b1},
            // two-byte message, final at phase 1
            '{8'hFF, 1'b0, 1'b1, 1'b0, "_", 8'h00, 1'b0},
            '{8'hFF, 1'b1, 1'b1, 1'b1, "_", "8", 1'b1},
            // block of zeros not final, then block of ones final
            '{8'h00, 1'b0, 1'b1, 1'b0, "A", 8'h00, 1'b0},
            '{8'h00, 1'b0, 1'b1, 1'b0, "A", 8'h00, 1'b0},
            '{8'h00, 1'b0, 1'b1, 1'b1, "A", "A", 1'b0},
            '{8'hFF, 1'b0, 1'b1, 1'b0, "_", 8'h00, 1'b0},
            '{8'hFF, 1'b0, 1'b1, 1'b0, "_", 8'h00, 1'b0},
            '{8'hFF, 1'b1, 1'b1, 1'b1, "_", "_", 1'b1},
            // mixed patterns left to the bench encoder
            '{8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
            '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
            '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
            '{8'hAA, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
            '{8'h55, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
            '{8'h3E, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0},
            '{8'hFE, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0}
        };
        foreach (dir_rows[i])
            feed_byte(dir_rows[i]);
        pause_sender();

        // random messages, mostly short, some long, a few single bytes
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            case ($urandom_range(99) / 5)
                0:       msg_len = 1;
                1, 2:    msg_len = $urandom_range(40, 9);
                default: msg_len = $urandom_range(8, 1);
            endcase
            for (int k = 0; k < msg_len; k++)
            begin
                steady = (sent >= 200 && sent < 450);
                if (sent == 600)
                    hold_req = 1'b1;
                if (sent == 800)
                    pause_sender();
                row = '0;
                if ($urandom_range(99) < 10)
                    row.data = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    row.data = 8'($urandom);
                row.fin = (k == msg_len - 1);
                feed_byte(row);
                sent++;
            end
        end
        msg_if.valid <= 1'b0;

        // drain, then let any stray item show up
        while (pending_syms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
